// ----- hdl/retry_backoff_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Retry backoff scheduler assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef RETRY_BACKOFF_SCHEDULER_DEFINES_SVH
`define RETRY_BACKOFF_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define RBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("retry_backoff_scheduler: port check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define RBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("retry_backoff_scheduler: port check failed");

`endif

// ----- hdl/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Retry backoff scheduler package
// Widths, operation and register codes, and the adder request type.
// ----------------------------------------------------------------------------
`default_nettype none

package rbs_pkg;

  localparam int WORD_W    = 32;
  localparam int TIME_W    = 64;
  localparam int DELAY_W   = WORD_W + 1;
  localparam int ADDR_W    = 4;
  localparam int DIGIT_W_DEF = 8;

  // Operation codes of an input word; the spare code acts as a query
  localparam logic [1:0] OP_QUERY   = 2'd0;
  localparam logic [1:0] OP_SUCCESS = 2'd1;
  localparam logic [1:0] OP_FAILURE = 2'd2;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_RETRY_BASE      = 2'd0;
  localparam logic [1:0] REG_RETRY_MAX       = 2'd1;
  localparam logic [1:0] REG_UPDATE_INTERVAL = 2'd2;

  // Request to the digit-serial adder
  typedef struct packed {
    logic start;
    logic sub;
  } alu_req_t;

endpackage

`default_nettype wire

// ----- hdl/rbs_backoff.sv -----
// ----------------------------------------------------------------------------
// Backoff delay unit
// Doubles the base once per cycle up to the cap, then takes the jitter as
// random mod (delay/4 + 1) with a one-bit-per-cycle restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_backoff (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [rbs_pkg::WORD_W-1:0]   base,
  input  wire logic [rbs_pkg::WORD_W-1:0]   cap,
  input  wire logic [rbs_pkg::WORD_W-1:0]   count,
  input  wire logic [rbs_pkg::WORD_W-1:0]   rnd,
  output logic                              done,
  output logic [rbs_pkg::DELAY_W-1:0]       total
);

  localparam int W    = rbs_pkg::WORD_W;
  localparam int BITW = $clog2(W);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DOUBLE,
    B_CLAMP,
    B_DIVIDE,
    B_SUM
  } bo_state_t;

  bo_state_t                 state_r;
  logic [W-1:0]              delay_r;
  logic [W-1:0]              cap_r;
  logic [W-1:0]              steps_r;
  logic [W-1:0]              rnd_r;
  logic [W-2:0]              div_r;
  logic [W-2:0]              rem_r;
  logic [BITW-1:0]           bit_r;
  logic [rbs_pkg::DELAY_W-1:0] total_r;
  logic                      done_r;

  logic                      grow;
  logic [W-1:0]              double_nxt;
  logic [W-1:0]              clamp_nxt;
  logic [W-3:0]              span_nxt;
  logic [W-1:0]              trial;
  logic                      fits;
  logic [W-1:0]              diff;

  // Doubling step: stop at the cap, at zero, or when the count runs out
  always_comb begin
    grow       = (steps_r != '0) && (delay_r != '0) && (delay_r < cap_r);
    double_nxt = (delay_r > (cap_r >> 1)) ? cap_r : {delay_r[W-2:0], 1'b0};
    clamp_nxt  = (delay_r > cap_r) ? cap_r : delay_r;
    span_nxt   = clamp_nxt[W-1:2];
  end

  // Restoring divide step, one random bit a cycle, MSB first
  always_comb begin
    trial = {rem_r, rnd_r[W-1]};
    fits  = (trial >= {1'b0, div_r});
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (start) begin
            delay_r <= base;
            cap_r   <= cap;
            steps_r <= count - W'(1);
            rnd_r   <= rnd;
            state_r <= B_DOUBLE;
          end
        end
        B_DOUBLE: begin
          if (grow) begin
            delay_r <= double_nxt;
            steps_r <= steps_r - W'(1);
          end else begin
            state_r <= B_CLAMP;
          end
        end
        B_CLAMP: begin
          // Clamp to the cap and set up the jitter divisor
          delay_r <= clamp_nxt;
          div_r   <= {1'b0, span_nxt} + (W-1)'(1);
          rem_r   <= '0;
          bit_r   <= BITW'(W - 1);
          state_r <= (span_nxt == '0) ? B_SUM : B_DIVIDE;
        end
        B_DIVIDE: begin
          rem_r <= fits ? diff[W-2:0] : trial[W-2:0];
          rnd_r <= {rnd_r[W-2:0], 1'b0};
          bit_r <= bit_r - BITW'(1);
          if (bit_r == '0) begin
            state_r <= B_SUM;
          end
        end
        B_SUM: begin
          total_r <= {1'b0, delay_r} + {2'b00, rem_r};
          done_r  <= 1'b1;
          state_r <= B_IDLE;
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  assign done  = done_r;
  assign total = total_r;

endmodule

`default_nettype wire

// ----- hdl/rbs_serial_alu.sv -----
// ----------------------------------------------------------------------------
// Digit-serial time adder
// Adds or subtracts two 64-bit words one digit a cycle, LSB first, through
// shift registers; the final carry gives saturation or the compare result.
// ----------------------------------------------------------------------------
`default_nettype none

module rbs_serial_alu #(
  parameter int DIGIT_W = rbs_pkg::DIGIT_W_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rbs_pkg::alu_req_t            req,
  input  wire logic [rbs_pkg::TIME_W-1:0]   a,
  input  wire logic [rbs_pkg::TIME_W-1:0]   b,
  output logic                              done,
  output logic [rbs_pkg::TIME_W-1:0]        sum,
  output logic                              carry
);

  localparam int TW   = rbs_pkg::TIME_W;
  localparam int NDIG = TW / DIGIT_W;
  localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;

  logic [TW-1:0]      a_r;
  logic [TW-1:0]      b_r;
  logic [TW-1:0]      sum_r;
  logic               carry_r;
  logic [CW-1:0]      cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [DIGIT_W:0]   digit_nxt;
  logic [TW-1:0]      sum_nxt;

  // One digit of the add, shifted in at the top of the result
  always_comb begin
    digit_nxt = {1'b0, a_r[DIGIT_W-1:0]} + {1'b0, b_r[DIGIT_W-1:0]}
              + (DIGIT_W+1)'(carry_r);
    sum_nxt   = (sum_r >> DIGIT_W) | (TW'(digit_nxt[DIGIT_W-1:0]) << (TW - DIGIT_W));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // Subtract is a + ~b + 1
        a_r     <= a;
        b_r     <= req.sub ? ~b : b;
        carry_r <= req.sub;
        cnt_r   <= CW'(NDIG - 1);
        busy_r  <= 1'b1;
      end else if (busy_r) begin
        a_r     <= a_r >> DIGIT_W;
        b_r     <= b_r >> DIGIT_W;
        sum_r   <= sum_nxt;
        carry_r <= digit_nxt[DIGIT_W];
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  assign done  = done_r;
  assign sum   = sum_r;
  assign carry = carry_r;

endmodule

`default_nettype wire

// ----- hdl/retry_backoff_scheduler.sv -----
// ----------------------------------------------------------------------------
// Retry backoff scheduler
// One word in, one word out, one word at a time. A query and a success
// run through the digit-serial 64-bit time adder. A failure first runs the
// backoff unit, which doubles the base until it reaches the cap, clamps,
// runs the bit-serial jitter divider when delay/4 is not zero and sums,
// and then hands its total to the adder. The finished word sits in an
// output register, so the next input word is taken while it waits.
// Failure count, next attempt and last success reset to zero; the
// configuration registers reset to base 1, cap 3600 and update interval
// 3600. The user must write them over the APB port only while the block
// is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module retry_backoff_scheduler #(
  parameter int DIGIT_W = rbs_pkg::DIGIT_W_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_operation,
  input  wire logic [rbs_pkg::TIME_W-1:0]    in_now,
  input  wire logic [rbs_pkg::WORD_W-1:0]    in_random_word,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_due,
  output logic [rbs_pkg::TIME_W-1:0]         out_next_attempt,
  output logic [rbs_pkg::WORD_W-1:0]         out_failure_count,
  output logic [rbs_pkg::TIME_W-1:0]         out_last_success,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rbs_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [rbs_pkg::WORD_W-1:0]    pwdata,
  output logic [rbs_pkg::WORD_W-1:0]         prdata,
  output logic                               pready
);

  localparam int TW = rbs_pkg::TIME_W;
  localparam int WW = rbs_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_BACKOFF,
    S_ALU,
    S_PUSH
  } sched_state_t;

  sched_state_t        state_r;
  logic [1:0]          op_r;
  logic [TW-1:0]       now_r;
  logic [WW-1:0]       rnd_r;
  logic                zero_r;

  logic [WW-1:0]       failures_r;
  logic [TW-1:0]       next_time_r;
  logic [TW-1:0]       success_r;
  logic                due_r;

  logic [WW-1:0]       retry_base_r;
  logic [WW-1:0]       retry_max_r;
  logic [WW-1:0]       update_interval_r;

  logic                out_valid_r;
  logic                out_due_r;
  logic [TW-1:0]       out_next_r;
  logic [WW-1:0]       out_count_r;
  logic [TW-1:0]       out_success_r;

  logic                in_take;
  logic                cfg_write;
  logic [1:0]          reg_idx;
  logic                is_update;
  logic                out_free;
  logic                push;

  rbs_pkg::alu_req_t   alu_req;
  logic [TW-1:0]       alu_b;
  logic                alu_done;
  logic [TW-1:0]       alu_sum;
  logic                alu_carry;

  logic                bo_start;
  logic                bo_done;
  logic [rbs_pkg::DELAY_W-1:0] bo_total;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[3:2];
  assign is_update = (op_r == rbs_pkg::OP_SUCCESS) || (op_r == rbs_pkg::OP_FAILURE);
  assign out_free  = !out_valid_r || !out_stall;
  assign push      = (state_r == S_PUSH) && out_free;

  // Register readback
  always_comb begin
    unique case (reg_idx)
      rbs_pkg::REG_RETRY_BASE:      prdata = retry_base_r;
      rbs_pkg::REG_RETRY_MAX:       prdata = retry_max_r;
      rbs_pkg::REG_UPDATE_INTERVAL: prdata = update_interval_r;
      default:                      prdata = '0;
    endcase
  end

  // Launch the backoff unit on a failure, the adder otherwise
  always_comb begin
    bo_start    = (state_r == S_DISPATCH) && (op_r == rbs_pkg::OP_FAILURE);
    alu_req.sub = 1'b0;
    alu_b       = {{(TW-rbs_pkg::DELAY_W){1'b0}}, bo_total};
    if (state_r == S_DISPATCH) begin
      if (op_r == rbs_pkg::OP_SUCCESS) begin
        alu_b = {{(TW-WW){1'b0}}, update_interval_r};
      end else begin
        alu_b       = next_time_r;
        alu_req.sub = 1'b1;
      end
    end
    alu_req.start = ((state_r == S_DISPATCH) && (op_r != rbs_pkg::OP_FAILURE))
                  || ((state_r == S_BACKOFF) && bo_done);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_base_r      <= WW'(1);
      retry_max_r       <= WW'(3600);
      update_interval_r <= WW'(3600);
    end else if (cfg_write) begin
      unique case (reg_idx)
        rbs_pkg::REG_RETRY_BASE:      retry_base_r      <= pwdata;
        rbs_pkg::REG_RETRY_MAX:       retry_max_r       <= pwdata;
        rbs_pkg::REG_UPDATE_INTERVAL: update_interval_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Sequencer, scheduler state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      failures_r  <= '0;
      next_time_r <= '0;
      success_r   <= '0;
    end else begin
      // Raise valid on a push, hold it while stalled, drop it once taken
      out_valid_r <= push || (out_valid_r && out_stall);
      if (alu_req.start) begin
        zero_r <= (alu_b == '0);
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            op_r  <= in_operation;
            now_r <= in_now;
            rnd_r <= in_random_word;
            if (in_operation == rbs_pkg::OP_SUCCESS) begin
              failures_r <= '0;
              success_r  <= in_now;
            end else if (in_operation == rbs_pkg::OP_FAILURE) begin
              if (failures_r != '1) begin
                failures_r <= failures_r + WW'(1);
              end
            end
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_r <= (op_r == rbs_pkg::OP_FAILURE) ? S_BACKOFF : S_ALU;
        end
        S_BACKOFF: begin
          if (bo_done) begin
            state_r <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            if (is_update) begin
              // Saturate on carry; due only when nothing was added or time is at its end
              next_time_r <= alu_carry ? '1 : alu_sum;
              due_r       <= zero_r || (now_r == '1);
            end else begin
              due_r <= alu_carry;
            end
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (push) begin
            out_due_r     <= due_r;
            out_next_r    <= next_time_r;
            out_count_r   <= failures_r;
            out_success_r <= success_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  rbs_backoff u_backoff (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bo_start),
    .base  (retry_base_r),
    .cap   (retry_max_r),
    .count (failures_r),
    .rnd   (rnd_r),
    .done  (bo_done),
    .total (bo_total)
  );

  rbs_serial_alu #(
    .DIGIT_W (DIGIT_W)
  ) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (now_r),
    .b     (alu_b),
    .done  (alu_done),
    .sum   (alu_sum),
    .carry (alu_carry)
  );

  assign out_valid         = out_valid_r;
  assign out_due           = out_due_r;
  assign out_next_attempt  = out_next_r;
  assign out_failure_count = out_count_r;
  assign out_last_success  = out_success_r;

endmodule

`default_nettype wire

// ----- hdl/rbs_checker.sv -----
// ----------------------------------------------------------------------------
// Retry backoff scheduler port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "retry_backoff_scheduler_defines.svh"

module rbs_port_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_due,
  input wire logic [rbs_pkg::TIME_W-1:0]    out_next_attempt,
  input wire logic [rbs_pkg::WORD_W-1:0]    out_failure_count,
  input wire logic [rbs_pkg::TIME_W-1:0]    out_last_success
);

  // Hold a stalled result word
  `RBS_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_due) && $stable(out_next_attempt)
                  && $stable(out_failure_count) && $stable(out_last_success))

  // Stall the input while a word is being worked on
  `RBS_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall)

  // No result can appear the cycle after a word is taken
  `RBS_ASSERT_NXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid))

  // A new result only comes out of a busy sequencer
  `RBS_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind retry_backoff_scheduler rbs_port_checker u_rbs_checker (.*);

`default_nettype wire
